[rtl/edfst_pkg.sv]
// ----------------------------------------------------------------------------
// edfst_pkg
// Shared types, widths and codes for the EDF schedulability test block.
// ----------------------------------------------------------------------------
package edfst_pkg;

    // Default parameter values
    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed widths
    localparam int DATA_W    = 32;
    localparam int LEN_W     = 48;
    localparam int SUM_W     = 61;
    localparam int DIV_NUM_W = 56;
    localparam int LIMIT_W   = 24;
    localparam int UTIL_W    = 24;

    localparam logic [LEN_W-1:0]   LEN_CAP   = '1;
    localparam logic [SUM_W-1:0]   SUM_CAP   = {1'b1, 60'd0};
    localparam logic [UTIL_W-1:0]  UTIL_CAP  = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 24'd1048576;

    // Status codes
    localparam logic [1:0] STATUS_DECIDED     = 2'd0;
    localparam logic [1:0] STATUS_LIMIT       = 2'd1;
    localparam logic [1:0] STATUS_TOO_MANY    = 2'd2;
    localparam logic [1:0] STATUS_ZERO_PERIOD = 2'd3;

    // Register index, taken from paddr[2]
    localparam logic REG_ITER_LIMIT = 1'b0;

    typedef struct packed {
        logic [DATA_W-1:0] exec_time;
        logic [DATA_W-1:0] task_period;
        logic [DATA_W-1:0] rel_deadline;
        logic              last_task;
    } edfst_in_t;

    typedef struct packed {
        logic              schedulable;
        logic [UTIL_W-1:0] utilization_q16;
        logic [1:0]        status;
    } edfst_out_t;

    typedef enum logic [1:0] {
        DIV_UTIL,
        DIV_DENS,
        DIV_BUSY
    } div_sel_t;

    typedef enum logic [2:0] {
        RES_TOO_MANY,
        RES_ZERO_PERIOD,
        RES_FAIL,
        RES_PASS,
        RES_LIMIT
    } res_code_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_U_RD,
        ST_U_LAT,
        ST_U_OP,
        ST_U_DIV1,
        ST_U_DIV2,
        ST_U_NEXT,
        ST_U_END,
        ST_B_RD,
        ST_B_LAT,
        ST_B_ACC,
        ST_I_TOP,
        ST_I_RD,
        ST_I_LAT,
        ST_I_OP,
        ST_I_DIV,
        ST_I_MUL1,
        ST_I_MUL2,
        ST_I_ACC,
        ST_I_CMP,
        ST_W_SRD,
        ST_W_SLAT,
        ST_W_CHK,
        ST_W_TRD,
        ST_W_TLAT,
        ST_W_ADD,
        ST_W_UPD,
        ST_OUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic      store;
        logic      set_clear;
        logic      idx_clr;
        logic      idx_inc;
        logic      idx_best;
        logic      lat_task;
        logic      sum_clr;
        logic      zero_set;
        logic      div_start;
        div_sel_t  div_sel;
        logic      acc_util;
        logic      acc_dens;
        logic      acc_dens_inf;
        logic      len_clr;
        logic      len_add_e;
        logic      len_load_nl;
        logic      steps_clr;
        logic      steps_inc;
        logic      nl_clr;
        logic      c_set;
        logic      mul_lo;
        logic      mul_hi;
        logic      nl_acc;
        logic      min_upd;
        logic      dem_clr;
        logic      dem_add;
        logic      nd_init;
        logic      nd_upd;
        logic      res_set;
        res_code_t res_code;
        logic      out_load;
    } edfst_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic ovf;
        logic p_zero;
        logic m_zero;
        logic zero_seen;
        logic div_done;
        logic last_idx;
        logic util_hi;
        logic dens_ok;
        logic busy_stop;
        logic walk_limit;
        logic nl_eq;
        logic min_gt_len;
        logic dem_gt_min;
    } edfst_stat_t;

endpackage

[rtl/edf_schedulability_test_top.sv]
// ----------------------------------------------------------------------------
// edf_schedulability_test_top
// EDF schedulability test by processor demand analysis.
// ----------------------------------------------------------------------------
// Usage:
//   Tasks arrive on the s_ channel, one per transaction, one per cycle while
//   the block is loading. A transaction with last_task set closes the set and
//   starts the analysis; s_ready stays low until its result is in the output
//   register. One result per set leaves on the m_ channel.
//   Analysis of the n stored tasks computes utilization and density (up to
//   two divisions per task in the shared restoring divider), seeds the busy
//   period, runs busy period steps (one division per task) and then deadline
//   walk steps (a serial minimum search over the next deadline memory). Step
//   counts are data dependent and capped by iteration_limit. Loading sustains
//   one task per cycle.
//   The result waits in an output register; while the receiver stalls the
//   block still loads the next set, and only holds the next result until the
//   output register empties.
//   Reset clears the task count and sequencer and sets iteration_limit to
//   1048576; the task memories need no clearing. iteration_limit sits at APB
//   address 0. Write it only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module edf_schedulability_test_top
    import edfst_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  edfst_in_t   s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output edfst_out_t  m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [LIMIT_W-1:0] limit_reg;
    edfst_cmd_t         cmd;
    edfst_stat_t        stat;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_ITER_LIMIT)) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ITER_LIMIT) ? {8'd0, limit_reg} : 32'd0;
    assign pready = 1'b1;

    edfst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_task),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    edfst_dp #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_data     (s_data),
        .iter_limit (limit_reg),
        .cmd        (cmd),
        .stat       (stat),
        .m_data     (m_data)
    );

endmodule

[rtl/edfst_ram.sv]
// ----------------------------------------------------------------------------
// edfst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module edfst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/edfst_div.sv]
// ----------------------------------------------------------------------------
// edfst_div
// Restoring divider, one quotient bit per cycle, with inexact flag.
// ----------------------------------------------------------------------------
module edfst_div
    import edfst_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DATA_W-1:0]    den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot,
    output logic                 rem_nz
);

    localparam int CW = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DATA_W:0]      rem_reg, rem_next;
    logic [DATA_W-1:0]    den_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg, done_reg;
    logic [DATA_W:0]      trial, diff;
    logic                 ge;

    // One restoring step
    always_comb begin
        trial    = {rem_reg[DATA_W-1:0], num_reg[DIV_NUM_W-1]};
        ge       = (trial >= {1'b0, den_reg});
        diff     = trial - {1'b0, den_reg};
        rem_next = ge ? diff : trial;
        num_next = {num_reg[DIV_NUM_W-2:0], ge};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done   = done_reg;
    assign quot   = num_reg;
    assign rem_nz = |rem_reg;

endmodule

[rtl/edfst_dp.sv]
// ----------------------------------------------------------------------------
// edfst_dp
// Datapath: task stores, sums, busy period, deadline walk and result.
// ----------------------------------------------------------------------------
module edfst_dp
    import edfst_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  edfst_in_t          s_data,
    input  logic [LIMIT_W-1:0] iter_limit,
    input  edfst_cmd_t         cmd,
    output edfst_stat_t        stat,
    output edfst_out_t         m_data
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TASK_W = 3 * DATA_W;
    localparam logic [DATA_W-1:0] TIME_MASK =
        (TIME_BITS >= DATA_W) ? '1 : DATA_W'((64'd1 << TIME_BITS) - 64'd1);
    localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;

    logic [CNT_W-1:0]     cnt_reg;
    logic                 ovf_reg;
    logic [IDX_W-1:0]     idx_reg, best_reg;
    logic [DATA_W-1:0]    e_reg, p_reg, d_reg, m_val;
    logic [SUM_W-1:0]     usum_reg, dsum_reg;
    logic                 zero_reg;
    logic [LEN_W-1:0]     len_reg, nl_reg, c_reg, min_reg, dem_reg;
    logic [LIMIT_W-1:0]   steps_reg;
    logic [55:0]          plo_reg, phi_reg;
    edfst_out_t           res_reg, m_data_reg;

    logic                 task_we, cnt_lt;
    logic [TASK_W-1:0]    task_wdata, task_rdata;
    logic                 nd_we;
    logic [IDX_W-1:0]     nd_waddr;
    logic [LEN_W-1:0]     nd_wdata, nd_rdata;
    logic [DIV_NUM_W-1:0] div_num, div_q;
    logic [DATA_W-1:0]    div_den;
    logic                 div_done, div_rem_nz;
    logic [SUM_W-1:0]     dens_q, inf_q;
    logic [LEN_W-1:0]     prod_sat, nd_sum;
    logic [56:0]          prod_sum;
    logic [LEN_W:0]       nd_sum_w;
    logic [UTIL_W-1:0]    util_val;

    function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, SUM_CAP}) ? SUM_CAP : s[SUM_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] len_sat(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? LEN_CAP : s[LEN_W-1:0];
    endfunction

    // Task stores
    assign cnt_lt     = (cnt_reg < CNT_W'(MAX_TASKS));
    assign task_we    = cmd.store && cnt_lt;
    assign task_wdata = {s_data.exec_time & TIME_MASK, s_data.task_period & TIME_MASK,
                         s_data.rel_deadline & TIME_MASK};

    edfst_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_task_ram (
        .aclk  (aclk),
        .we    (task_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (task_wdata),
        .raddr (idx_reg),
        .rdata (task_rdata)
    );

    // Next deadline store
    assign nd_sum_w = {1'b0, min_reg} + {{(LEN_W-DATA_W+1){1'b0}}, p_reg};
    assign nd_sum   = nd_sum_w[LEN_W] ? LEN_CAP : nd_sum_w[LEN_W-1:0];
    assign nd_we    = cmd.nd_init || cmd.nd_upd;
    assign nd_waddr = cmd.nd_upd ? best_reg : idx_reg;
    assign nd_wdata = cmd.nd_upd ? nd_sum : LEN_W'(d_reg);

    edfst_ram #(.WIDTH(LEN_W), .DEPTH(MAX_TASKS)) u_nd_ram (
        .aclk  (aclk),
        .we    (nd_we),
        .waddr (nd_waddr),
        .wdata (nd_wdata),
        .raddr (idx_reg),
        .rdata (nd_rdata)
    );

    // Divider operand select
    assign m_val = (d_reg < p_reg) ? d_reg : p_reg;
    always_comb begin
        unique case (cmd.div_sel)
            DIV_UTIL: begin
                div_num = DIV_NUM_W'(e_reg) << FRAC_BITS;
                div_den = p_reg;
            end
            DIV_DENS: begin
                div_num = DIV_NUM_W'(e_reg) << FRAC_BITS;
                div_den = m_val;
            end
            DIV_BUSY: begin
                div_num = DIV_NUM_W'(len_reg);
                div_den = p_reg;
            end
            default: begin
                div_num = '0;
                div_den = p_reg;
            end
        endcase
    end

    edfst_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q),
        .rem_nz  (div_rem_nz)
    );

    // Sum terms and saturated product; the upper partial product sits 24 bits up
    assign dens_q   = SUM_W'(div_q) + SUM_W'(div_rem_nz);
    assign inf_q    = (e_reg != '0) ? SUM_CAP : '0;
    assign prod_sum = {9'd0, phi_reg[23:0], 24'd0} + {1'b0, plo_reg};
    assign prod_sat = ((|phi_reg[55:24]) || (prod_sum > 57'(LEN_CAP))) ?
                      LEN_CAP : prod_sum[LEN_W-1:0];
    assign util_val = (usum_reg > SUM_W'(UTIL_CAP)) ? UTIL_CAP : usum_reg[UTIL_W-1:0];

    // Control state: task count and overflow
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.set_clear) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.store) begin
            if (cnt_lt) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end else if (cmd.idx_best) begin
            idx_reg <= best_reg;
        end
        if (cmd.lat_task) begin
            {e_reg, p_reg, d_reg} <= task_rdata;
        end
        if (cmd.sum_clr) begin
            usum_reg <= '0;
            dsum_reg <= '0;
            zero_reg <= 1'b0;
        end else begin
            if (cmd.zero_set) zero_reg <= 1'b1;
            if (cmd.acc_util) usum_reg <= sum_sat(usum_reg, SUM_W'(div_q));
            if (cmd.acc_dens) dsum_reg <= sum_sat(dsum_reg, dens_q);
            if (cmd.acc_dens_inf) dsum_reg <= sum_sat(dsum_reg, inf_q);
        end
        if (cmd.len_clr) begin
            len_reg <= '0;
        end else if (cmd.len_add_e) begin
            len_reg <= len_sat(len_reg, LEN_W'(e_reg));
        end else if (cmd.len_load_nl) begin
            len_reg <= nl_reg;
        end
        if (cmd.steps_clr) begin
            steps_reg <= '0;
        end else if (cmd.steps_inc) begin
            steps_reg <= steps_reg + LIMIT_W'(1);
        end
        if (cmd.nl_clr) begin
            nl_reg <= '0;
        end else if (cmd.nl_acc) begin
            nl_reg <= len_sat(nl_reg, prod_sat);
        end
        if (cmd.c_set) c_reg <= LEN_W'(div_q) + LEN_W'(div_rem_nz);
        if (cmd.mul_lo) plo_reg <= c_reg[23:0] * e_reg;
        if (cmd.mul_hi) phi_reg <= c_reg[47:24] * e_reg;
        if (cmd.min_upd && ((idx_reg == '0) || (nd_rdata < min_reg))) begin
            min_reg  <= nd_rdata;
            best_reg <= idx_reg;
        end
        if (cmd.dem_clr) begin
            dem_reg <= '0;
        end else if (cmd.dem_add) begin
            dem_reg <= len_sat(dem_reg, LEN_W'(e_reg));
        end
        if (cmd.res_set) begin
            unique case (cmd.res_code)
                RES_TOO_MANY:    res_reg <= '{1'b0, '0, STATUS_TOO_MANY};
                RES_ZERO_PERIOD: res_reg <= '{1'b0, '0, STATUS_ZERO_PERIOD};
                RES_FAIL:        res_reg <= '{1'b0, util_val, STATUS_DECIDED};
                RES_PASS:        res_reg <= '{1'b1, util_val, STATUS_DECIDED};
                RES_LIMIT:       res_reg <= '{1'b0, util_val, STATUS_LIMIT};
                default:         res_reg <= '{1'b0, '0, STATUS_DECIDED};
            endcase
        end
        if (cmd.out_load) m_data_reg <= res_reg;
    end

    // Status to controller
    always_comb begin
        stat.ovf        = ovf_reg;
        stat.p_zero     = (p_reg == '0);
        stat.m_zero     = (m_val == '0);
        stat.zero_seen  = zero_reg;
        stat.div_done   = div_done;
        stat.last_idx   = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
        stat.util_hi    = (usum_reg > ONE);
        stat.dens_ok    = (dsum_reg <= ONE);
        stat.busy_stop  = (len_reg >= LEN_CAP) || (steps_reg >= iter_limit);
        stat.walk_limit = (steps_reg >= iter_limit);
        stat.nl_eq      = (nl_reg == len_reg);
        stat.min_gt_len = (min_reg > len_reg);
        stat.dem_gt_min = (dem_reg > min_reg);
    end

    assign m_data = m_data_reg;

endmodule

[rtl/edfst_ctrl.sv]
// ----------------------------------------------------------------------------
// edfst_ctrl
// Sequencer for loading, utilization, busy period and deadline walk.
// ----------------------------------------------------------------------------
module edfst_ctrl
    import edfst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_last,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  edfst_stat_t stat,
    output edfst_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // State and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.div_sel  = DIV_UTIL;
        cmd.res_code = RES_FAIL;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.store = 1'b1;
                    if (s_last) state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.ovf) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = RES_TOO_MANY;
                    state_next   = ST_OUT;
                end else begin
                    cmd.idx_clr = 1'b1;
                    cmd.sum_clr = 1'b1;
                    state_next  = ST_U_RD;
                end
            end
            ST_U_RD: state_next = ST_U_LAT;
            ST_U_LAT: begin
                cmd.lat_task = 1'b1;
                state_next   = ST_U_OP;
            end
            ST_U_OP: begin
                if (stat.p_zero) begin
                    cmd.zero_set = 1'b1;
                    state_next   = ST_U_NEXT;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_UTIL;
                    state_next    = ST_U_DIV1;
                end
            end
            ST_U_DIV1: begin
                if (stat.div_done) begin
                    cmd.acc_util = 1'b1;
                    if (stat.m_zero) begin
                        cmd.acc_dens_inf = 1'b1;
                        state_next       = ST_U_NEXT;
                    end else begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_DENS;
                        state_next    = ST_U_DIV2;
                    end
                end
            end
            ST_U_DIV2: begin
                cmd.div_sel = DIV_DENS;
                if (stat.div_done) begin
                    cmd.acc_dens = 1'b1;
                    state_next   = ST_U_NEXT;
                end
            end
            ST_U_NEXT: begin
                if (stat.last_idx) begin
                    state_next = ST_U_END;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_U_RD;
                end
            end
            // Decide on zero period, utilization and density
            ST_U_END: begin
                priority if (stat.zero_seen) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = RES_ZERO_PERIOD;
                    state_next   = ST_OUT;
                end else if (stat.util_hi) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = RES_FAIL;
                    state_next   = ST_OUT;
                end else if (stat.dens_ok) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = RES_PASS;
                    state_next   = ST_OUT;
                end else begin
                    cmd.idx_clr = 1'b1;
                    cmd.len_clr = 1'b1;
                    state_next  = ST_B_RD;
                end
            end
            // Seed busy length and next deadlines
            ST_B_RD: state_next = ST_B_LAT;
            ST_B_LAT: begin
                cmd.lat_task = 1'b1;
                state_next   = ST_B_ACC;
            end
            ST_B_ACC: begin
                cmd.len_add_e = 1'b1;
                cmd.nd_init   = 1'b1;
                if (stat.last_idx) begin
                    cmd.steps_clr = 1'b1;
                    state_next    = ST_I_TOP;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_B_RD;
                end
            end
            // Busy period fixpoint
            ST_I_TOP: begin
                if (stat.busy_stop) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = RES_LIMIT;
                    state_next   = ST_OUT;
                end else begin
                    cmd.steps_inc = 1'b1;
                    cmd.nl_clr    = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    state_next    = ST_I_RD;
                end
            end
            ST_I_RD: state_next = ST_I_LAT;
            ST_I_LAT: begin
                cmd.lat_task = 1'b1;
                state_next   = ST_I_OP;
            end
            ST_I_OP: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_BUSY;
                state_next    = ST_I_DIV;
            end
            ST_I_DIV: begin
                cmd.div_sel = DIV_BUSY;
                if (stat.div_done) begin
                    cmd.c_set  = 1'b1;
                    state_next = ST_I_MUL1;
                end
            end
            ST_I_MUL1: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_I_MUL2;
            end
            ST_I_MUL2: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_I_ACC;
            end
            ST_I_ACC: begin
                cmd.nl_acc = 1'b1;
                if (stat.last_idx) begin
                    state_next = ST_I_CMP;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_I_RD;
                end
            end
            ST_I_CMP: begin
                if (stat.nl_eq) begin
                    cmd.idx_clr   = 1'b1;
                    cmd.steps_clr = 1'b1;
                    cmd.dem_clr   = 1'b1;
                    state_next    = ST_W_SRD;
                end else begin
                    cmd.len_load_nl = 1'b1;
                    state_next      = ST_I_TOP;
                end
            end
            // Deadline walk: scan for the earliest next deadline
            ST_W_SRD: state_next = ST_W_SLAT;
            ST_W_SLAT: begin
                cmd.min_upd = 1'b1;
                if (stat.last_idx) begin
                    state_next = ST_W_CHK;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_W_SRD;
                end
            end
            ST_W_CHK: begin
                priority if (stat.min_gt_len) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = RES_PASS;
                    state_next   = ST_OUT;
                end else if (stat.walk_limit) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = RES_LIMIT;
                    state_next   = ST_OUT;
                end else begin
                    cmd.steps_inc = 1'b1;
                    cmd.idx_best  = 1'b1;
                    state_next    = ST_W_TRD;
                end
            end
            ST_W_TRD: state_next = ST_W_TLAT;
            ST_W_TLAT: begin
                cmd.lat_task = 1'b1;
                state_next   = ST_W_ADD;
            end
            ST_W_ADD: begin
                cmd.dem_add = 1'b1;
                state_next  = ST_W_UPD;
            end
            ST_W_UPD: begin
                if (stat.dem_gt_min) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = RES_FAIL;
                    state_next   = ST_OUT;
                end else begin
                    cmd.nd_upd  = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_W_SRD;
                end
            end
            // Hand the result to the output register once it is free
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load  = 1'b1;
                    cmd.set_clear = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

[rtl/edfst_checker.sv]
// ----------------------------------------------------------------------------
// edfst_checker
// Port-level assertions for the EDF schedulability test block.
// ----------------------------------------------------------------------------
module edfst_checker
    import edfst_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input edfst_in_t   s_data,
    input logic        m_valid,
    input logic        m_ready,
    input edfst_out_t  m_data,
    input logic        pready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Error results carry no verdict and no utilization
    a_err_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_TOO_MANY ||
                    m_data.status == STATUS_ZERO_PERIOD)
        |-> !m_data.schedulable && (m_data.utilization_q16 == '0))
        else $error("error result with verdict or utilization");

    // Iteration limit never reports schedulable
    a_limit_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_LIMIT) |-> !m_data.schedulable)
        else $error("limit result marked schedulable");

    // Keep loading one task per cycle until the last task
    a_load_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.last_task |=> s_ready)
        else $error("loading stalled before last task");

    // Configuration port is never held off
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind edf_schedulability_test_top edfst_checker u_edfst_checker (.*);
